// ===== hdl/lfps_pkg.sv =====
package lfps_pkg;

    localparam int SENSOR_COUNT   = 8;
    localparam int IGNORED_SENSOR = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    typedef logic signed [4:0] t_weight;

    localparam t_weight SENSOR_WEIGHTS [SENSOR_COUNT] = '{
        5'sd8, 5'sd4, 5'sd2, 5'sd1, -5'sd1, 5'sd0, -5'sd4, -5'sd8
    };

    // Operating modes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WAIT = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT     = 3'd6;

    // Register reset values.
    localparam logic [23:0] KP_RST       = 24'd65536;
    localparam logic [23:0] KI_RST       = 24'd131072;
    localparam logic [23:0] KD_RST       = 24'd66;
    localparam logic [7:0]  CENTER_RST   = 8'd80;
    localparam logic [7:0]  DUTY_MAX_RST = 8'd90;
    localparam logic [7:0]  DUTY_MIN_RST = 8'd70;
    localparam logic [15:0] WAIT_RST     = 16'd1000;

    // floor(x / 6) = (x * RECIP_SIX) >> RECIP_SHIFT for every x below 2**19.
    localparam logic [23:0] RECIP_SIX   = 24'd349526;
    localparam int          RECIP_SHIFT = 21;

    typedef struct packed {
        logic [23:0] kp;
        logic [23:0] ki;
        logic [23:0] kd;
        logic [7:0]  center_init;
        logic [7:0]  duty_max;
        logic [7:0]  duty_min;
        logic [15:0] wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic load_init;
        logic do_err;
        logic do_int;
        logic do_c0;
        logic do_c1;
        logic do_scale;
        logic do_recip;
        logic do_limit;
    } t_dp_cmd;

    typedef struct packed {
        logic line_in;
    } t_dp_stat;

endpackage

// ===== hdl/lfps_regs.sv =====
module lfps_regs import lfps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp          <= KP_RST;
            r_cfg.ki          <= KI_RST;
            r_cfg.kd          <= KD_RST;
            r_cfg.center_init <= CENTER_RST;
            r_cfg.duty_max    <= DUTY_MAX_RST;
            r_cfg.duty_min    <= DUTY_MIN_RST;
            r_cfg.wait_ticks  <= WAIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KP:       r_cfg.kp          <= i_cfg_data;
                CFG_KI:       r_cfg.ki          <= i_cfg_data;
                CFG_KD:       r_cfg.kd          <= i_cfg_data;
                CFG_CENTER:   r_cfg.center_init <= i_cfg_data[7:0];
                CFG_DUTY_MAX: r_cfg.duty_max    <= i_cfg_data[7:0];
                CFG_DUTY_MIN: r_cfg.duty_min    <= i_cfg_data[7:0];
                CFG_WAIT:     r_cfg.wait_ticks  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/lfps_dp.sv =====
module lfps_dp import lfps_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  t_cfg                    i_cfg,
    input  logic [SENSOR_COUNT-1:0] i_line_sensors,
    output t_dp_stat                o_stat,
    output logic [7:0]              o_steer_duty,
    output logic                    o_line_seen
);

    logic [SENSOR_COUNT-1:0] r_sens;
    logic signed [5:0]       r_prev_err;
    logic signed [39:0]      r_integ;
    logic [7:0]              r_center;
    logic [7:0]              r_out_duty;
    logic signed [5:0]       r_e;
    logic signed [5:0]       r_d;
    logic signed [43:0]      r_prod;
    logic signed [41:0]      r_c;
    logic [17:0]             r_x;
    logic                    r_neg;

    logic signed [5:0]  w_err;
    logic signed [5:0]  w_diff;
    logic               w_mid;
    logic [23:0]        w_mul_a;
    logic signed [18:0] w_mul_b;
    logic signed [43:0] w_prod;
    logic signed [40:0] w_isum;
    logic signed [39:0] w_isat;
    logic [41:0]        w_mag;
    logic [25:0]        w_tmag;
    logic               w_cneg;
    logic [15:0]        w_tsat;
    logic [17:0]        w_nmag;
    logic [17:0]        w_x;
    logic [15:0]        w_q;
    logic signed [17:0] w_v;
    logic [7:0]         w_lim;

    // Weighted error over the sensor bits; the ignored sensor never counts.
    always_comb begin
        w_err = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (r_sens[i] && (i != IGNORED_SENSOR)) begin
                w_err = w_err + 6'(SENSOR_WEIGHTS[i]);
            end
        end
    end

    assign w_mid  = r_sens[3] & r_sens[4];
    assign w_diff = w_mid ? 6'sd0 : (w_err - r_prev_err);

    // One shared multiplier: unsigned gain or reciprocal times a signed operand.
    always_comb begin
        if (i_cmd.do_err) begin
            w_mul_a = i_cfg.ki;
            w_mul_b = 19'(w_err);
        end else if (i_cmd.do_int) begin
            w_mul_a = i_cfg.kp;
            w_mul_b = 19'(r_e);
        end else if (i_cmd.do_c0) begin
            w_mul_a = i_cfg.kd;
            w_mul_b = 19'(r_d);
        end else begin
            w_mul_a = RECIP_SIX;
            w_mul_b = $signed({1'b0, r_x});
        end
    end

    assign w_prod = $signed({1'b0, w_mul_a}) * w_mul_b;

    // Integral update with saturation to 40 bits.
    assign w_isum = 41'(r_integ) + 41'(r_prod);
    always_comb begin
        if (w_isum[40] != w_isum[39]) begin
            w_isat = w_isum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
            w_isat = w_isum[39:0];
        end
    end

    // Truncate the signed Q26.16 sum toward zero, saturate to 16 bits, scale by five.
    assign w_cneg = r_c[41];
    assign w_mag  = w_cneg ? 42'(-r_c) : 42'(r_c);
    assign w_tmag = w_mag[41:16];
    always_comb begin
        if (w_cneg) begin
            w_tsat = (w_tmag > 26'd32768) ? 16'd32768 : w_tmag[15:0];
        end else begin
            w_tsat = (w_tmag > 26'd32767) ? 16'd32767 : w_tmag[15:0];
        end
    end
    assign w_nmag = 18'({w_tsat, 2'b00}) + 18'(w_tsat);
    // A rounded-up quotient of a positive value is floor((n + 5) / 6).
    assign w_x    = w_cneg ? w_nmag : (w_nmag + 18'd5);

    assign w_q = r_prod[RECIP_SHIFT +: 16];
    assign w_v = r_neg ? (18'(r_center) + 18'(w_q)) : (18'(r_center) - 18'(w_q));

    // Upper limit is tested first; it wins crossed limits unless w_v is negative.
    always_comb begin
        if (w_v[17]) begin
            w_lim = i_cfg.duty_min;
        end else if (w_v[16:0] >= 17'(i_cfg.duty_max)) begin
            w_lim = i_cfg.duty_max;
        end else if (w_v[16:0] < 17'(i_cfg.duty_min)) begin
            w_lim = i_cfg.duty_min;
        end else begin
            w_lim = w_v[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
            r_center   <= CENTER_RST;
            r_out_duty <= CENTER_RST;
        end else begin
            if (i_cmd.load_init) begin
                r_center   <= i_cfg.center_init;
                r_out_duty <= i_cfg.center_init;
            end
            if (i_cmd.do_err) begin
                r_prev_err <= w_err;
                if (w_mid) begin
                    r_integ  <= '0;
                    r_center <= r_out_duty;
                end
            end
            if (i_cmd.do_int) begin
                r_integ <= w_isat;
            end
            if (i_cmd.do_limit) begin
                r_out_duty <= w_lim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sens <= i_line_sensors;
        end
        if (i_cmd.do_err) begin
            r_e <= w_err;
            r_d <= w_diff;
        end
        if (i_cmd.do_err || i_cmd.do_int || i_cmd.do_c0 || i_cmd.do_recip) begin
            r_prod <= w_prod;
        end
        if (i_cmd.do_c0) begin
            r_c <= 42'(r_prod) + 42'(r_integ);
        end else if (i_cmd.do_c1) begin
            r_c <= r_c + 42'(r_prod);
        end
        if (i_cmd.do_scale) begin
            r_x   <= w_x;
            r_neg <= w_cneg;
        end
    end

    assign o_stat.line_in = |i_line_sensors;
    assign o_steer_duty   = r_out_duty;
    assign o_line_seen    = |r_sens;

endmodule

// ===== hdl/lfps_ctrl.sv =====
module lfps_ctrl import lfps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_dp_stat    i_stat,
    input  logic [15:0] i_wait_ticks,
    input  logic        i_slot_free,
    output t_dp_cmd     o_cmd,
    output logic        o_done,
    output logic        o_servo_write,
    output logic [1:0]  o_mode_now
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ERR   = 4'd1;
    localparam logic [3:0] ST_INT   = 4'd2;
    localparam logic [3:0] ST_C0    = 4'd3;
    localparam logic [3:0] ST_C1    = 4'd4;
    localparam logic [3:0] ST_SCALE = 4'd5;
    localparam logic [3:0] ST_RECIP = 4'd6;
    localparam logic [3:0] ST_LIMIT = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]  r_state, n_state;
    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_wait_cnt, n_wait_cnt;
    logic [1:0]  r_mode_now, n_mode_now;
    logic        r_servo_wr, n_servo_wr;
    logic [15:0] w_wait_inc;
    logic        w_accept;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_wait_inc = (r_wait_cnt != 16'hFFFF) ? (r_wait_cnt + 16'd1) : r_wait_cnt;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_wait_cnt = r_wait_cnt;
        n_mode_now = r_mode_now;
        n_servo_wr = r_servo_wr;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_mode_now    = r_mode;
                    n_servo_wr    = 1'b0;
                    n_state       = ST_DONE;
                    case (r_mode)
                        MODE_IDLE: begin
                            o_cmd.load_init = 1'b1;
                            n_servo_wr      = 1'b1;
                            n_wait_cnt      = '0;
                            n_mode          = MODE_WAIT;
                        end
                        MODE_WAIT: begin
                            n_wait_cnt = w_wait_inc;
                            if (w_wait_inc >= i_wait_ticks) begin
                                n_mode = MODE_RUN;
                            end
                        end
                        MODE_RUN: begin
                            if (i_stat.line_in) begin
                                n_state = ST_ERR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ERR: begin
                o_cmd.do_err = 1'b1;
                n_state      = ST_INT;
            end
            ST_INT: begin
                o_cmd.do_int = 1'b1;
                n_state      = ST_C0;
            end
            ST_C0: begin
                o_cmd.do_c0 = 1'b1;
                n_state     = ST_C1;
            end
            ST_C1: begin
                o_cmd.do_c1 = 1'b1;
                n_state     = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.do_scale = 1'b1;
                n_state        = ST_RECIP;
            end
            ST_RECIP: begin
                o_cmd.do_recip = 1'b1;
                n_state        = ST_LIMIT;
            end
            ST_LIMIT: begin
                o_cmd.do_limit = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= MODE_IDLE;
            r_wait_cnt <= '0;
            r_mode_now <= MODE_IDLE;
            r_servo_wr <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_wait_cnt <= n_wait_cnt;
            r_mode_now <= n_mode_now;
            r_servo_wr <= n_servo_wr;
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_done        = (r_state == ST_DONE);
    assign o_servo_write = r_servo_wr;
    assign o_mode_now    = r_mode_now;

    // A control tick that sees the line must start the PID sequence.
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_mode == MODE_RUN) && i_stat.line_in) |=> (r_state == ST_ERR))
        else $error("control tick with line did not start the PID sequence");

    // Once control has started, only reset leaves it.
    a_run_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_RUN) |=> (r_mode == MODE_RUN))
        else $error("left control mode without reset");

    // The start-up counter and the mode only move on an accepted tick.
    a_wait_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_wait_cnt) && $stable(r_mode))
        else $error("mode or wait counter changed without a transfer");

endmodule

// ===== hdl/line_follow_pid_steering.sv =====
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_ready   | i_line_sensors
// result  | out       | o_out_valid / i_out_ready | o_steer_duty, o_servo_write,
//         |           |                           | o_servo_value, o_run_mode, o_line_seen
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A control tick that sees the line passes from accept through seven steps (err, int, c0
// and recip share one 25x19 multiplier), then a handoff to the output register before the
// next ready. Start-up ticks and ticks without the line go from accept straight to handoff.
// Reset is synchronous and active low; it restores register defaults and the idle mode.
// A stalled result sits in the output register while the next tick is processed; the
// sequencer then waits in its handoff state until that register is free.
// The config port is always ready and writes take effect at the transfer.
module line_follow_pid_steering import lfps_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SENSOR_COUNT-1:0] i_line_sensors,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [7:0]              o_steer_duty,
    output logic                    o_servo_write,
    output logic [7:0]              o_servo_value,
    output logic [1:0]              o_run_mode,
    output logic                    o_line_seen,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic       w_done;
    logic       w_slot_free;
    logic       w_load;
    logic       w_servo_wr;
    logic [1:0] w_mode_now;
    logic [7:0] w_duty;
    logic       w_line_seen;

    logic       r_out_valid;
    logic [7:0] r_steer;
    logic       r_servo_wr;
    logic [7:0] r_servo_val;
    logic [1:0] r_mode;
    logic       r_line;

    lfps_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lfps_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stat        (w_stat),
        .i_wait_ticks  (w_cfg.wait_ticks),
        .i_slot_free   (w_slot_free),
        .o_cmd         (w_cmd),
        .o_done        (w_done),
        .o_servo_write (w_servo_wr),
        .o_mode_now    (w_mode_now)
    );

    lfps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg          (w_cfg),
        .i_line_sensors (i_line_sensors),
        .o_stat         (w_stat),
        .o_steer_duty   (w_duty),
        .o_line_seen    (w_line_seen)
    );

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_load      = w_done && w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_steer     <= w_duty;
            r_servo_wr  <= w_servo_wr;
            r_servo_val <= w_servo_wr ? w_duty : 8'd0;
            r_mode      <= w_mode_now;
            r_line      <= w_line_seen;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_steer_duty  = r_steer;
    assign o_servo_write = r_servo_wr;
    assign o_servo_value = r_servo_val;
    assign o_run_mode    = r_mode;
    assign o_line_seen   = r_line;

endmodule
